// File: hdl/stkalloc_pkg.sv
// Shared constants, types and helpers of the stack allocator.
package stkalloc_pkg;

  localparam int unsigned MARKER_DEPTH = 128;
  localparam int unsigned OFFSET_BITS  = 16;
  localparam int unsigned MARK_IDX_W   = (MARKER_DEPTH > 1) ? $clog2(MARKER_DEPTH) : 1;
  localparam int unsigned MARK_CNT_W   = $clog2(MARKER_DEPTH + 1);
  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned SIZE_W       = 16;
  localparam int unsigned BYTES_W      = 16;
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned WIDE_W       = 33;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_RESET = 2'd2,
    KIND_NOP   = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 3'd0,
    STS_NOMEM = 3'd1,
    STS_ZERO  = 3'd2,
    STS_EMPTY = 3'd3,
    STS_FULL  = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE = 1'd0,
    CFG_POOL_LEN  = 1'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [SIZE_W-1:0]  request_bytes;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   block_address;
    logic [BYTES_W-1:0]  freed_bytes;
    logic [BYTES_W-1:0]  used_bytes;
  } rsp_t;

  typedef struct packed {
    logic accept;
    logic commit;
    logic pop;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic pop_go;
    logic out_free;
  } sts_t;

  function automatic logic [BYTES_W-1:0] off_to_bytes(input logic [OFFSET_BITS-1:0] v);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(v);
    return w[BYTES_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] off_to_addr(input logic [OFFSET_BITS-1:0] v);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(v);
    return w[ADDR_W-1:0];
  endfunction

endpackage

// File: hdl/stkalloc_if.sv
// Valid/ready channel interfaces for request and result words.
interface stkalloc_req_if import stkalloc_pkg::*;;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface stkalloc_rsp_if import stkalloc_pkg::*;;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/stkalloc_ctrl.sv
// Request sequencer: accepts a word, then commits or pops and finishes.
module stkalloc_ctrl import stkalloc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_POP  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.pop_go) begin
          cmd_o.pop = 1'b1;
          state_d   = S_POP;
        end else if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_POP: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/stkalloc_dp.sv
// Datapath: pool registers, top and marker count, marker memory, result register.
module stkalloc_dp import stkalloc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  req_t                  req_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  output rsp_t                  rsp_o,
  output logic                  rsp_valid_o,
  input  logic                  rsp_ready_i
);

  logic [ADDR_W-1:0]      base_q;
  logic [SIZE_W-1:0]      size_q;
  logic [KIND_W-1:0]      kind_q;
  logic [SIZE_W-1:0]      reqb_q;
  logic [OFFSET_BITS-1:0] top_q, top_d;
  logic [MARK_CNT_W-1:0]  cnt_q, cnt_d;
  logic [OFFSET_BITS-1:0] mem [MARKER_DEPTH];
  logic [OFFSET_BITS-1:0] rd_q;
  logic                   out_valid_q, out_valid_d;
  rsp_t                   out_q, out_d;

  logic [WIDE_W-1:0]      wide_top, wide_size, wide_max, wide_cap, wide_rem, wide_req;
  logic [MARK_CNT_W-1:0]  cnt_dec;
  logic [MARK_IDX_W-1:0]  pop_idx;
  logic [MARK_IDX_W-1:0]  push_idx;
  logic                   is_full, is_empty;
  logic [OFFSET_BITS-1:0] top_sum, freed_off;
  logic                   push;
  status_e                res_status;
  logic [ADDR_W-1:0]      res_addr;
  logic [OFFSET_BITS-1:0] top_nx;
  logic [MARK_CNT_W-1:0]  cnt_nx;

  assign wide_top  = WIDE_W'(top_q);
  assign wide_size = WIDE_W'(size_q);
  assign wide_max  = WIDE_W'({OFFSET_BITS{1'b1}});
  assign wide_cap  = (wide_size < wide_max) ? wide_size : wide_max;
  assign wide_rem  = (wide_top <= wide_cap) ? (wide_cap - wide_top) : '0;
  assign wide_req  = WIDE_W'(reqb_q);
  assign is_full   = (cnt_q == MARK_CNT_W'(MARKER_DEPTH));
  assign is_empty  = (cnt_q == '0);
  assign cnt_dec   = cnt_q - MARK_CNT_W'(1);
  assign pop_idx   = cnt_dec[MARK_IDX_W-1:0];
  assign push_idx  = cnt_q[MARK_IDX_W-1:0];
  assign top_sum   = top_q + OFFSET_BITS'(reqb_q);
  assign freed_off = top_q - rd_q;

  assign sts_o.pop_go   = (kind_e'(kind_q) == KIND_FREE) && !is_empty;
  assign sts_o.out_free = !out_valid_q || rsp_ready_i;

  always_comb begin
    push       = 1'b0;
    res_status = STS_OK;
    res_addr   = '0;
    top_nx     = top_q;
    cnt_nx     = cnt_q;
    unique case (kind_e'(kind_q))
      KIND_ALLOC: begin
        if (wide_req > wide_rem) begin
          res_status = STS_NOMEM;
        end else if (reqb_q == '0) begin
          res_status = STS_ZERO;
        end else if (is_full) begin
          res_status = STS_FULL;
        end else begin
          push     = 1'b1;
          top_nx   = top_sum;
          cnt_nx   = cnt_q + MARK_CNT_W'(1);
          res_addr = base_q + off_to_addr(top_q);
        end
      end
      KIND_FREE: begin
        res_status = STS_EMPTY;
      end
      KIND_RESET: begin
        top_nx = '0;
        cnt_nx = '0;
      end
      KIND_NOP: begin
        res_status = STS_OK;
      end
      default: begin
        res_status = STS_OK;
      end
    endcase
  end

  always_comb begin
    top_d       = top_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !rsp_ready_i;
    if (cmd_i.commit) begin
      top_d               = top_nx;
      cnt_d               = cnt_nx;
      out_valid_d         = 1'b1;
      out_d.status        = res_status;
      out_d.block_address = res_addr;
      out_d.freed_bytes   = '0;
      out_d.used_bytes    = off_to_bytes(top_nx);
    end
    if (cmd_i.pop) begin
      cnt_d = cnt_dec;
    end
    if (cmd_i.finish) begin
      top_d               = rd_q;
      out_valid_d         = 1'b1;
      out_d.status        = STS_OK;
      out_d.block_address = base_q + off_to_addr(rd_q);
      out_d.freed_bytes   = off_to_bytes(freed_off);
      out_d.used_bytes    = off_to_bytes(rd_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      size_q      <= SIZE_W'(128);
      top_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_POOL_BASE: base_q <= cfg_data_i[ADDR_W-1:0];
          CFG_POOL_LEN:  size_q <= cfg_data_i[SIZE_W-1:0];
          default: ;
        endcase
      end
      top_q       <= top_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= req_i.kind;
      reqb_q <= req_i.request_bytes;
    end
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && push) begin
      mem[push_idx] <= top_q;
    end
    if (cmd_i.pop) begin
      rd_q <= mem[pop_idx];
    end
  end

  assign rsp_o       = out_q;
  assign rsp_valid_o = out_valid_q;

endmodule

// File: hdl/stack_allocator_with_markers_core.sv
// Top level of the stack allocator with marker stack.
// Bump-pointer allocator over one pool at pool_base whose length in bytes is set by
// the second configuration register, with a marker stack of MARKER_DEPTH entries
// held in a single-port memory. One request is in flight at a time. Allocate, reset,
// nop, a rejected request and free on an empty stack load the result register from
// the execute state once the request is accepted; a free that releases a block first
// passes through the pop state, for the registered read of the marker memory. A new
// request is taken in the cycle after the result register is loaded, even while that
// result still waits downstream; a full result register stalls completion. The marker
// memory needs no clearing after reset: only entries below the marker count are read.
module stack_allocator_with_markers_core import stkalloc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  stkalloc_req_if.sink          req_i,
  stkalloc_rsp_if.source        rsp_o
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;
  rsp_t out_data;

  stkalloc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  stkalloc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (req_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (out_data),
    .rsp_valid_o (out_valid),
    .rsp_ready_i (rsp_o.ready)
  );

  assign req_i.ready = in_ready;
  assign rsp_o.valid = out_valid;
  assign rsp_o.data  = out_data;

endmodule

// File: hdl/stkalloc_chk.sv
// Port-level checker for the stack allocator, bound to the top level.
module stkalloc_chk import stkalloc_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input rsp_t rsp_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_i))
    else $error("result word dropped or changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_i.status != STS_OK) |->
      (rsp_i.block_address == '0) && (rsp_i.freed_bytes == '0))
    else $error("error result carries an address or size");

  a_freed_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_i.freed_bytes != '0) |-> (rsp_i.status == STS_OK))
    else $error("freed size on a failed request");

  a_one_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while another is in flight");

endmodule

bind stack_allocator_with_markers_core stkalloc_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_i       (rsp_o.data)
);
